FILE: sv/bsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg
// Types and constants shared by the bitset set-operation pipeline.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int SET_BITS   = 256;
  localparam int WORD_BITS  = 64;
  localparam int CMD_W      = 4;
  localparam int ELEM_W     = 8;
  localparam int CNT_W      = 4;
  localparam int MAX_CHUNKS = 8;

  // slave tdata layout
  localparam int IN_CMD_LSB = 0;
  localparam int IN_A_LSB   = IN_CMD_LSB + CMD_W;
  localparam int IN_B_LSB   = IN_A_LSB + SET_BITS;
  localparam int IN_LO_LSB  = IN_B_LSB + SET_BITS;
  localparam int IN_HI_LSB  = IN_LO_LSB + ELEM_W;
  localparam int IN_USED_W  = IN_HI_LSB + ELEM_W;
  localparam int S_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // master tdata layout
  localparam int OUT_RES_LSB   = 0;
  localparam int OUT_CNT_LSB   = OUT_RES_LSB + SET_BITS;
  localparam int OUT_TRUTH_LSB = OUT_CNT_LSB + CNT_W;
  localparam int OUT_USED_W    = OUT_TRUTH_LSB + 1;
  localparam int M_DATA_W      = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = M_DATA_W - OUT_USED_W;

  typedef logic [SET_BITS-1:0]   set_t;
  typedef logic [ELEM_W-1:0]     elem_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [MAX_CHUNKS-1:0] nz_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_UNION     = 4'd0,
    CMD_INTERSECT = 4'd1,
    CMD_DIFF      = 4'd2,
    CMD_XOR       = 4'd3,
    CMD_MEMBER    = 4'd4,
    CMD_ADD       = 4'd5,
    CMD_ADD_RANGE = 4'd6,
    CMD_REMOVE    = 4'd7,
    CMD_EQUAL     = 4'd8,
    CMD_SUBSET    = 4'd9
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    set_t             a;
    set_t             b;
    elem_t            lo;
    elem_t            hi;
  } op_in_t;

  typedef struct packed {
    set_t r;
    logic truth;
  } op_res_t;

  typedef struct packed {
    set_t r;
    logic truth;
    nz_t  nz;
  } flag_res_t;

  typedef struct packed {
    set_t r;
    cnt_t chunks;
    logic truth;
  } out_res_t;

  function automatic set_t low_mask(int unsigned n);
    set_t m;
    m = '0;
    for (int unsigned i = 0; i < SET_BITS; i++) begin
      m[i] = (i < n);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: sv/pascal_bitset_alu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pascal_bitset_alu_core
// Set unit: union, intersection, difference, xor, member, add, add range,
// remove, equality and subset on 256-element bitsets.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while m_tready is high; four register stages (capture, set op,
//   chunk flags, size/output) each hold one item with its own valid bit.
// Backpressure ripples back only through full stages.
// Reset clears the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module pascal_bitset_alu_core import bsa_pkg::*; #(
  parameter int SET_CHUNKS = 8,
  parameter int CHUNK_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // cmd[3:0], set_a_w0..w3[259:4], set_b_w0..w3[515:260],
  // low_value[523:516], high_value[531:524], zero pad[535:532]
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // res_w0..w3[255:0], res_chunks[259:256], truth[260], zero pad[263:261]
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int UNIV = (SET_CHUNKS * CHUNK_BITS > SET_BITS) ? SET_BITS
                                                             : SET_CHUNKS * CHUNK_BITS;
  localparam set_t UMASK = low_mask(UNIV);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  op_in_t    s1;
  op_res_t   s2;
  flag_res_t s3;
  out_res_t  s4;

  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign s_tready = rdy1;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // capture, bits outside the universe dropped
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1.cmd <= s_tdata[IN_CMD_LSB +: CMD_W];
      s1.a   <= s_tdata[IN_A_LSB +: SET_BITS] & UMASK;
      s1.b   <= s_tdata[IN_B_LSB +: SET_BITS] & UMASK;
      s1.lo  <= s_tdata[IN_LO_LSB +: ELEM_W];
      s1.hi  <= s_tdata[IN_HI_LSB +: ELEM_W];
    end
  end

  bsa_op_stage #(
    .UNIV (UNIV)
  ) u_op (
    .clk  (clk),
    .en   (rdy2),
    .din  (s1),
    .dout (s2)
  );

  bsa_flag_stage #(
    .SET_CHUNKS (SET_CHUNKS),
    .CHUNK_BITS (CHUNK_BITS)
  ) u_flag (
    .clk  (clk),
    .en   (rdy3),
    .din  (s2),
    .dout (s3)
  );

  bsa_out_stage #(
    .SET_CHUNKS (SET_CHUNKS)
  ) u_out (
    .clk  (clk),
    .en   (rdy4),
    .din  (s3),
    .dout (s4)
  );

  assign m_tdata = {{OUT_PAD_W{1'b0}}, s4.truth, s4.chunks, s4.r};

  a_truth_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && s4.truth |-> (s4.r == '0) && (s4.chunks == '0))
    else $error("truth answer with a nonempty result set");

  a_size_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((s4.chunks == '0) == (s4.r == '0)))
    else $error("result size disagrees with result set");

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (int'(s4.chunks) <= SET_CHUNKS))
    else $error("result size beyond chunk count");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && v3 && v4)
    else $error("input stalled with a free stage");

endmodule
`default_nettype wire

FILE: sv/bsa_op_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_op_stage
// Set operation stage: computes the result set and the truth bit.
// ----------------------------------------------------------------------------
module bsa_op_stage import bsa_pkg::*; #(
  parameter int UNIV = 256
) (
  input  logic    clk,
  input  logic    en,
  input  op_in_t  din,
  output op_res_t dout
);

  localparam set_t UMASK = low_mask(UNIV);

  set_t    rng;
  set_t    one;
  op_res_t res;

  always_comb begin
    for (int e = 0; e < SET_BITS; e++) begin
      rng[e] = (ELEM_W'(e) >= din.lo) && (ELEM_W'(e) <= din.hi);
    end
  end

  assign one = set_t'(1) << din.lo;

  always_comb begin
    res = '0;
    unique case (din.cmd)
      CMD_UNION:     res.r = din.a | din.b;
      CMD_INTERSECT: res.r = din.a & din.b;
      CMD_DIFF:      res.r = din.a & ~din.b;
      CMD_XOR:       res.r = din.a ^ din.b;
      CMD_MEMBER:    res.truth = din.a[din.lo];
      CMD_ADD:       res.r = din.a | (one & UMASK);
      CMD_ADD_RANGE: res.r = din.a | (rng & UMASK);
      CMD_REMOVE:    res.r = din.a & ~one;
      CMD_EQUAL:     res.truth = (din.a == din.b);
      CMD_SUBSET:    res.truth = ((din.a & ~din.b) == '0);
      default:       res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= res;
    end
  end

endmodule
`default_nettype wire

FILE: sv/bsa_flag_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_flag_stage
// Chunk occupancy stage: one nonzero flag per chunk of the result set.
// ----------------------------------------------------------------------------
module bsa_flag_stage import bsa_pkg::*; #(
  parameter int SET_CHUNKS = 8,
  parameter int CHUNK_BITS = 32
) (
  input  logic      clk,
  input  logic      en,
  input  op_res_t   din,
  output flag_res_t dout
);

  function automatic set_t chunk_mask(int idx);
    set_t m;
    m = '0;
    for (int b = 0; b < SET_BITS; b++) begin
      m[b] = (b >= idx * CHUNK_BITS) && (b < (idx + 1) * CHUNK_BITS);
    end
    return m;
  endfunction

  nz_t nz;

  always_comb begin
    nz = '0;
    for (int i = 0; i < SET_CHUNKS; i++) begin
      nz[i] = |(din.r & chunk_mask(i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.r     <= din.r;
      dout.truth <= din.truth;
      dout.nz    <= nz;
    end
  end

endmodule
`default_nettype wire

FILE: sv/bsa_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_out_stage
// Size stage: highest occupied chunk plus one, into the output register.
// ----------------------------------------------------------------------------
module bsa_out_stage import bsa_pkg::*; #(
  parameter int SET_CHUNKS = 8
) (
  input  logic      clk,
  input  logic      en,
  input  flag_res_t din,
  output out_res_t  dout
);

  cnt_t cnt;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < SET_CHUNKS; i++) begin
      if (din.nz[i]) begin
        cnt = CNT_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.r      <= din.r;
      dout.chunks <= cnt;
      dout.truth  <= din.truth;
    end
  end

endmodule
`default_nettype wire
